@@ hdl/assert_macros.svh @@
// assertion macros for the port checker file
// no dependencies; expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

@@ hdl/bsd_pkg.sv @@
// body sleep detector: shared types, register codes and helpers
// no dependencies
package bsd_pkg;

	localparam int unsigned BSD_MAX_BODIES = 256;
	localparam int unsigned IDX_W          = 8;
	localparam int unsigned MOT_W          = 32;
	localparam int unsigned CNT_W          = 8;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned CFG_DATA_W     = 32;
	// depth that an 8 bit index can reach
	localparam int unsigned IDX_SPAN       = 256;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BIAS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_LIM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAKE_LIM   = 2'd2;

	// reset values: 0.9 in Q0.16, 0.08 and 0.18 in Q16.16
	localparam logic [15:0]      MIN_BIAS_RST  = 16'd58982;
	localparam logic [MOT_W-1:0] SLEEP_LIM_RST = 32'd5243;
	localparam logic [MOT_W-1:0] WAKE_LIM_RST  = 32'd11796;

	// item kinds
	localparam logic CMD_UPDATE  = 1'b0;
	localparam logic CMD_COLLIDE = 1'b1;

	typedef struct packed {
		logic             asleep;
		logic [MOT_W-1:0] motion;
		logic [CNT_W-1:0] count;
	} bsd_entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic minmax_en;
		logic mul_en;
		logic commit;
	} bsd_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic need_mix;
	} bsd_sts_t;

	// magnitude of a signed Q8.8 value; -32768 maps to 32768, still 16 bits
	function automatic logic [15:0] mag16(input logic [15:0] v);
		logic [15:0] r;
		r = v[15] ? (~v + 16'd1) : v;
		return r;
	endfunction

endpackage

@@ hdl/bsd_store.sv @@
// per-body state store: one write port, two registered read ports
// entries not yet written read as zero through a valid bit each; uses bsd_pkg
module bsd_store #(
	parameter int unsigned AW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr_a,
	input  logic [AW-1:0]       rd_addr_b,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  bsd_pkg::bsd_entry_t wr_data,
	output bsd_pkg::bsd_entry_t rd_data_a,
	output bsd_pkg::bsd_entry_t rd_data_b
);
	import bsd_pkg::*;

	localparam int unsigned DEPTH = 1 << AW;

	bsd_entry_t       mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	bsd_entry_t       rdat_a_q;
	bsd_entry_t       rdat_b_q;
	logic             rvld_a_q;
	logic             rvld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdat_a_q <= mem_q[rd_addr_a];
			rdat_b_q <= mem_q[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvld_a_q <= 1'b0;
			rvld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_a_q <= valid_q[rd_addr_a];
				rvld_b_q <= valid_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = rvld_a_q ? rdat_a_q : '0;
	assign rd_data_b = rvld_b_q ? rdat_b_q : '0;

endmodule

@@ hdl/bsd_datapath.sv @@
// datapath: item registers, motion squares, biased mix, counter and pair logic
// uses bsd_pkg and bsd_store
module bsd_datapath #(
	parameter int unsigned MAX_BODIES = bsd_pkg::BSD_MAX_BODIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bsd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bsd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                cmd,
	input  logic [bsd_pkg::IDX_W-1:0]           body_index,
	input  logic [bsd_pkg::IDX_W-1:0]           other_index,
	input  logic signed [15:0]                  speed,
	input  logic signed [15:0]                  spin_rate,
	input  logic                                force_applied,
	input  logic [bsd_pkg::CNT_W-1:0]           sleep_count_limit,
	input  logic                                pair_active,
	input  logic                                first_static,
	input  logic                                second_static,
	input  bsd_pkg::bsd_ctl_t                   ctl,
	output bsd_pkg::bsd_sts_t                   sts,
	output logic [bsd_pkg::IDX_W-1:0]           affected_body,
	output logic                                now_sleeping,
	output logic                                went_to_sleep,
	output logic                                woke_up,
	output logic [bsd_pkg::MOT_W-1:0]           motion_estimate,
	output logic [bsd_pkg::CNT_W-1:0]           quiet_count
);
	import bsd_pkg::*;

	localparam int unsigned DEPTH = (MAX_BODIES < IDX_SPAN) ? MAX_BODIES : IDX_SPAN;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam logic [16:0] MAXB  = 17'(MAX_BODIES);

	// configuration registers
	logic [15:0]      bias_q;
	logic [MOT_W-1:0] slim_q;
	logic [MOT_W-1:0] wlim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= MIN_BIAS_RST;
			slim_q <= SLEEP_LIM_RST;
			wlim_q <= WAKE_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_BIAS:  bias_q <= cfg_data[15:0];
				REG_SLEEP_LIM: slim_q <= cfg_data;
				REG_WAKE_LIM:  wlim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// index range checks on the incoming word
	logic a_in_rng;
	logic b_in_rng;
	assign a_in_rng = ({9'd0, body_index} < MAXB);
	assign b_in_rng = ({9'd0, other_index} < MAXB);
	assign sts.need_mix = (cmd == CMD_UPDATE) && !force_applied && a_in_rng;

	// item registers
	logic             cmd_q;
	logic [IDX_W-1:0] a_q;
	logic [IDX_W-1:0] b_q;
	logic             force_q;
	logic [CNT_W-1:0] limit_q;
	logic             active_q;
	logic             fst_q;
	logic             snd_q;
	logic             oor_q;
	logic [31:0]      sq_spd_q;
	logic [31:0]      sq_ang_q;
	logic [15:0]      mag_spd;
	logic [15:0]      mag_ang;

	assign mag_spd = mag16(speed);
	assign mag_ang = mag16(spin_rate);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd;
			a_q      <= body_index;
			b_q      <= other_index;
			force_q  <= force_applied;
			limit_q  <= sleep_count_limit;
			active_q <= pair_active;
			fst_q    <= first_static;
			snd_q    <= second_static;
			oor_q    <= !a_in_rng || ((cmd == CMD_COLLIDE) && !b_in_rng);
			sq_spd_q <= {16'd0, mag_spd} * {16'd0, mag_spd};
			sq_ang_q <= {16'd0, mag_ang} * {16'd0, mag_ang};
		end
	end

	// state store
	bsd_entry_t ent_a;
	bsd_entry_t ent_b;
	logic       wr_en;
	logic [IDX_W-1:0] wr_idx;
	bsd_entry_t wr_ent;

	bsd_store #(
		.AW (AW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (ctl.load),
		.rd_addr_a (body_index[AW-1:0]),
		.rd_addr_b (other_index[AW-1:0]),
		.wr_en     (wr_en),
		.wr_addr   (wr_idx[AW-1:0]),
		.wr_data   (wr_ent),
		.rd_data_a (ent_a),
		.rd_data_b (ent_b)
	);

	// stage 1: new motion, ordered against the old estimate
	logic [MOT_W-1:0] motion;
	logic [MOT_W-1:0] lo_s1;
	logic [MOT_W-1:0] hi_s1;

	assign motion = sq_spd_q + sq_ang_q;

	always_ff @(posedge clk) begin
		if (ctl.minmax_en) begin
			lo_s1 <= (ent_a.motion < motion) ? ent_a.motion : motion;
			hi_s1 <= (ent_a.motion < motion) ? motion : ent_a.motion;
		end
	end

	// stage 2: bias weighted products
	logic [16:0] wgt;
	logic [47:0] prod_lo_s2;
	logic [48:0] prod_hi_s2;

	assign wgt = 17'h10000 - {1'b0, bias_q};

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_lo_s2 <= {16'd0, lo_s1} * {32'd0, bias_q};
			prod_hi_s2 <= {17'd0, hi_s1} * {32'd0, wgt};
		end
	end

	// final step: rounding, counter, sleep decision, force wake, pair wake and range reject
	logic [48:0]      mix;
	logic [MOT_W-1:0] est;
	logic [CNT_W-1:0] cnt_inc;
	logic             quiet;
	logic             sa;
	logic             sb;
	logic [IDX_W-1:0] sleeper;
	bsd_entry_t       sl_ent;
	logic [MOT_W-1:0] mover_mot;

	logic [IDX_W-1:0] res_body;
	bsd_entry_t       res_ent;
	logic             res_went;
	logic             res_woke;

	assign mix       = {1'b0, prod_lo_s2} + prod_hi_s2 + 49'd32768;
	assign est       = mix[47:16];
	assign cnt_inc   = (ent_a.count != '1) ? ent_a.count + 8'd1 : ent_a.count;
	assign quiet     = (limit_q != '0) && (est < slim_q);
	assign sa        = ent_a.asleep;
	assign sb        = ent_b.asleep;
	assign sleeper   = sa ? a_q : b_q;
	assign sl_ent    = sa ? ent_a : ent_b;
	assign mover_mot = sa ? ent_b.motion : ent_a.motion;

	always_comb begin
		res_body = a_q;
		res_ent  = ent_a;
		res_went = 1'b0;
		res_woke = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = a_q;
		if (oor_q) begin
			res_ent = '0;
		end else if (cmd_q == CMD_UPDATE) begin
			wr_en = ctl.commit;
			if (force_q) begin
				res_ent.asleep = 1'b0;
				res_ent.count  = '0;
				res_woke       = ent_a.asleep;
			end else begin
				res_ent.motion = est;
				if (quiet) begin
					if (cnt_inc >= limit_q) begin
						res_ent.asleep = 1'b1;
						res_ent.count  = limit_q;
						res_ent.motion = '0;
						res_went       = 1'b1;
					end else begin
						res_ent.count = cnt_inc;
					end
				end else if (ent_a.count != '0) begin
					res_ent.count = ent_a.count - 8'd1;
				end
			end
		end else if (active_q && !fst_q && !snd_q && (sa != sb)) begin
			// pair with one sleeper: wake it when the mover is fast enough
			res_body = sleeper;
			res_ent  = sl_ent;
			wr_idx   = sleeper;
			if (mover_mot > wlim_q) begin
				wr_en          = ctl.commit;
				res_ent.asleep = 1'b0;
				res_ent.count  = '0;
				res_woke       = 1'b1;
			end
		end
	end

	assign wr_ent = res_ent;

	// result register
	logic [IDX_W-1:0] body_q;
	logic             sleep_q;
	logic             went_q;
	logic             woke_q;
	logic [MOT_W-1:0] est_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			body_q  <= res_body;
			sleep_q <= res_ent.asleep;
			went_q  <= res_went;
			woke_q  <= res_woke;
			est_q   <= res_ent.motion;
			cnt_q   <= res_ent.count;
		end
	end

	assign affected_body   = body_q;
	assign now_sleeping    = sleep_q;
	assign went_to_sleep   = went_q;
	assign woke_up         = woke_q;
	assign motion_estimate = est_q;
	assign quiet_count     = cnt_q;

endmodule

@@ hdl/bsd_ctrl.sv @@
// controller: sequences one word through read, the mix stages when needed, and commit
// drives the input stall and output valid; uses bsd_pkg
module bsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_stall,
	input  bsd_pkg::bsd_sts_t sts,
	output bsd_pkg::bsd_ctl_t ctl,
	output logic              in_stall,
	output logic              out_valid
);
	import bsd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MINMAX,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   out_valid_q;

	always_comb begin
		ctl.load      = in_valid && !in_stall_q;
		ctl.minmax_en = (state_q == ST_MINMAX);
		ctl.mul_en    = (state_q == ST_MUL);
		// result register free, or being emptied this cycle
		ctl.commit    = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_stall_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.load) begin
						state_q    <= sts.need_mix ? ST_MINMAX : ST_FIN;
						in_stall_q <= 1'b1;
					end
				end
				ST_MINMAX: state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_FIN;
				ST_FIN: begin
					if (ctl.commit) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = in_stall_q;
	assign out_valid = out_valid_q;

endmodule

@@ hdl/body_sleep_detector_unit.sv @@
// channel  | dir | handshake           | payload
// in       | in  | in_valid/in_stall   | cmd, body_index, other_index, speeds, flags, limit
// out      | out | out_valid/out_stall | affected_body, flags, motion_estimate, quiet_count
// cfg      | in  | cfg_we              | cfg_index, cfg_data
//
// a body update without force goes from acceptance through read, min/max, bias multiplies
// and commit, and the input stays closed until commit; commit waits on a stalled full result
// force, collision and out-of-range words skip the mix stages: read, then commit
// reset clears the body store through per-entry valid bits, no clearing pass
// a stalled result holds in the output register while the next word is accepted
// top level: uses bsd_pkg, bsd_ctrl, bsd_datapath
module body_sleep_detector_unit #(
	parameter int unsigned MAX_BODIES = bsd_pkg::BSD_MAX_BODIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [bsd_pkg::IDX_W-1:0]      body_index,
	input  logic [bsd_pkg::IDX_W-1:0]      other_index,
	input  logic signed [15:0]             speed,
	input  logic signed [15:0]             spin_rate,
	input  logic                           force_applied,
	input  logic [bsd_pkg::CNT_W-1:0]      sleep_count_limit,
	input  logic                           pair_active,
	input  logic                           first_static,
	input  logic                           second_static,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bsd_pkg::IDX_W-1:0]      affected_body,
	output logic                           now_sleeping,
	output logic                           went_to_sleep,
	output logic                           woke_up,
	output logic [bsd_pkg::MOT_W-1:0]      motion_estimate,
	output logic [bsd_pkg::CNT_W-1:0]      quiet_count
);
	import bsd_pkg::*;

	bsd_ctl_t ctl;
	bsd_sts_t sts;

	bsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	bsd_datapath #(
		.MAX_BODIES (MAX_BODIES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.cmd               (cmd),
		.body_index        (body_index),
		.other_index       (other_index),
		.speed             (speed),
		.spin_rate         (spin_rate),
		.force_applied     (force_applied),
		.sleep_count_limit (sleep_count_limit),
		.pair_active       (pair_active),
		.first_static      (first_static),
		.second_static     (second_static),
		.ctl               (ctl),
		.sts               (sts),
		.affected_body     (affected_body),
		.now_sleeping      (now_sleeping),
		.went_to_sleep     (went_to_sleep),
		.woke_up           (woke_up),
		.motion_estimate   (motion_estimate),
		.quiet_count       (quiet_count)
	);

endmodule

@@ hdl/bsd_checker.sv @@
// port-level checks for the body sleep detector, bound to the top level
// uses assert_macros.svh and bsd_pkg
`include "assert_macros.svh"

module bsd_port_checks (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           now_sleeping,
	input logic                           went_to_sleep,
	input logic                           woke_up,
	input logic [bsd_pkg::MOT_W-1:0]      motion_estimate,
	input logic [bsd_pkg::CNT_W-1:0]      quiet_count
);
	import bsd_pkg::*;

	// a result waiting on a stall stays offered
	`ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// one word at a time: the input closes right after a word is taken
	`ASSERT_NXT(a_one_word, in_valid && !in_stall, in_stall, "input open after accept")

	// input only closes because a word was taken
	`ASSERT_IMP(a_stall_cause, $rose(in_stall), $past(in_valid), "stall without a word")

	// falling asleep leaves the body asleep with a zero estimate
	`ASSERT_IMP(a_sleep_word, out_valid && went_to_sleep,
		now_sleeping && !woke_up && (motion_estimate == '0), "bad sleep word")

	// a woken body is awake with a cleared counter
	`ASSERT_IMP(a_wake_word, out_valid && woke_up,
		!now_sleeping && (quiet_count == '0), "bad wake word")

endmodule

bind body_sleep_detector_unit bsd_port_checks u_bsd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.now_sleeping    (now_sleeping),
	.went_to_sleep   (went_to_sleep),
	.woke_up         (woke_up),
	.motion_estimate (motion_estimate),
	.quiet_count     (quiet_count)
);

@@ sim/bsd_checker.sv @@
// checker for the body sleep detector: watches the config port and both channels,
// keeps its own copy of the body table and compares every result word
// depends on bsd_pkg
`timescale 1ns / 100ps

module bsd_checker
	import bsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  cmd,
	input  logic [IDX_W-1:0]      body_index,
	input  logic [IDX_W-1:0]      other_index,
	input  logic signed [15:0]    speed,
	input  logic signed [15:0]    spin_rate,
	input  logic                  force_applied,
	input  logic [CNT_W-1:0]      sleep_count_limit,
	input  logic                  pair_active,
	input  logic                  first_static,
	input  logic                  second_static,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [IDX_W-1:0]      affected_body,
	input  logic                  now_sleeping,
	input  logic                  went_to_sleep,
	input  logic                  woke_up,
	input  logic [MOT_W-1:0]      motion_estimate,
	input  logic [CNT_W-1:0]      quiet_count,
	output int                    mismatches,
	output int                    pending
);

	typedef struct packed {
		logic [IDX_W-1:0] body;
		logic             asleep;
		logic             went;
		logic             woke;
		logic [MOT_W-1:0] est;
		logic [CNT_W-1:0] cnt;
	} body_status_t;

	logic             asleep_tab [IDX_SPAN];
	logic [MOT_W-1:0] est_tab    [IDX_SPAN];
	logic [CNT_W-1:0] quiet_tab  [IDX_SPAN];
	logic [15:0]      bias;
	logic [MOT_W-1:0] sleep_lim;
	logic [MOT_W-1:0] wake_lim;

	body_status_t status_due [$];
	int           mismatch_total = 0;

	// square of the magnitude; -32768 gives 2^30
	function automatic logic [31:0] mag_sq(input logic [15:0] v);
		logic [31:0] m;
		m = v[15] ? (32'h10000 - {16'd0, v}) : {16'd0, v};
		return m * m;
	endfunction

	function automatic body_status_t step_bodies(
		input logic             c,
		input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b,
		input logic [15:0]      spd,
		input logic [15:0]      ang,
		input logic             frc,
		input logic [CNT_W-1:0] lim,
		input logic             pact,
		input logic             fst,
		input logic             sst
	);
		body_status_t     r;
		logic [31:0]      motion;
		logic [63:0]      lo, hi, mix;
		logic [IDX_W-1:0] sleeper, mover;
		r = '0;
		r.body = a;
		if (c == CMD_UPDATE) begin
			if (frc) begin
				r.woke = asleep_tab[a];
				asleep_tab[a] = 1'b0;
				quiet_tab[a] = '0;
			end else begin
				motion = mag_sq(spd) + mag_sq(ang);
				lo = {32'd0, (est_tab[a] < motion) ? est_tab[a] : motion};
				hi = {32'd0, (est_tab[a] < motion) ? motion : est_tab[a]};
				mix = lo * {48'd0, bias} + hi * (64'd65536 - {48'd0, bias}) + 64'd32768;
				est_tab[a] = mix[47:16];
				if (lim != 0 && est_tab[a] < sleep_lim) begin
					if (quiet_tab[a] != 8'hFF)
						quiet_tab[a] = quiet_tab[a] + 8'd1;
					// sleeping again still flags the host to zero velocities
					if (quiet_tab[a] >= lim) begin
						asleep_tab[a] = 1'b1;
						quiet_tab[a] = lim;
						est_tab[a] = '0;
						r.went = 1'b1;
					end
				end else if (quiet_tab[a] != 0) begin
					quiet_tab[a] = quiet_tab[a] - 8'd1;
				end
			end
		end else if (pact && !fst && !sst && asleep_tab[a] != asleep_tab[b]) begin
			sleeper = asleep_tab[a] ? a : b;
			mover = asleep_tab[a] ? b : a;
			r.body = sleeper;
			if (est_tab[mover] > wake_lim) begin
				asleep_tab[sleeper] = 1'b0;
				quiet_tab[sleeper] = '0;
				r.woke = 1'b1;
			end
		end
		r.asleep = asleep_tab[r.body];
		r.est = est_tab[r.body];
		r.cnt = quiet_tab[r.body];
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatch_total++;
		$display("%0t ns bsd mismatch: %s got %0h want %0h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		body_status_t want;
		body_status_t got;
		if (!arst_n) begin
			for (int i = 0; i < IDX_SPAN; i++) begin
				asleep_tab[i] = 1'b0;
				est_tab[i] = '0;
				quiet_tab[i] = '0;
			end
			bias = MIN_BIAS_RST;
			sleep_lim = SLEEP_LIM_RST;
			wake_lim = WAKE_LIM_RST;
			status_due.delete();
			pending <= 0;
			mismatches <= mismatch_total;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_BIAS:  bias = cfg_data[15:0];
					REG_SLEEP_LIM: sleep_lim = cfg_data;
					REG_WAKE_LIM:  wake_lim = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got.body = affected_body;
				got.asleep = now_sleeping;
				got.went = went_to_sleep;
				got.woke = woke_up;
				got.est = motion_estimate;
				got.cnt = quiet_count;
				if (status_due.size() == 0) begin
					report("result word with nothing pending, body", 32'(got.body), 32'd0);
				end else begin
					want = status_due.pop_front();
					if (got.body !== want.body)
						report("affected_body", 32'(got.body), 32'(want.body));
					if (got.asleep !== want.asleep)
						report("now_sleeping", 32'(got.asleep), 32'(want.asleep));
					if (got.went !== want.went)
						report("went_to_sleep", 32'(got.went), 32'(want.went));
					if (got.woke !== want.woke)
						report("woke_up", 32'(got.woke), 32'(want.woke));
					if (got.est !== want.est)
						report("motion_estimate", got.est, want.est);
					if (got.cnt !== want.cnt)
						report("quiet_count", 32'(got.cnt), 32'(want.cnt));
				end
			end
			if (in_valid && !in_stall)
				status_due.push_back(step_bodies(cmd, body_index, other_index, speed,
					spin_rate, force_applied, sleep_count_limit, pair_active,
					first_static, second_static));
			pending <= status_due.size();
			mismatches <= mismatch_total;
		end
	end

endmodule

@@ sim/body_sleep_detector_unit_tb.sv @@
// testbench top for body_sleep_detector_unit: directed and random body words,
// config phases, random stalls on both sides; checking is done by bsd_checker
// depends on bsd_pkg, bsd_checker and the block itself
`timescale 1ns / 100ps

module body_sleep_detector_unit_tb;
	import bsd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          HOLD_CYCLES = 80;
	localparam int          PHASE_WORDS = 100;

	typedef struct packed {
		logic             cmd;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [15:0]      spd;
		logic [15:0]      ang;
		logic             frc;
		logic [CNT_W-1:0] lim;
		logic             pact;
		logic             fst;
		logic             sst;
	} body_word_t;

	localparam int WORD_W = $bits(body_word_t);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  cmd = 1'b0;
	logic [IDX_W-1:0]      body_index = '0;
	logic [IDX_W-1:0]      other_index = '0;
	logic signed [15:0]    speed = '0;
	logic signed [15:0]    spin_rate = '0;
	logic                  force_applied = 1'b0;
	logic [CNT_W-1:0]      sleep_count_limit = '0;
	logic                  pair_active = 1'b0;
	logic                  first_static = 1'b0;
	logic                  second_static = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [IDX_W-1:0]      affected_body;
	logic                  now_sleeping;
	logic                  went_to_sleep;
	logic                  woke_up;
	logic [MOT_W-1:0]      motion_estimate;
	logic [CNT_W-1:0]      quiet_count;
	int                    mismatches;
	int                    pending;

	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	bit          sender_busy = 1'b1;
	int          words_sent = 0;
	int unsigned cycle_count = 0;
	logic [IDX_W-1:0] pool [6];

	body_sleep_detector_unit u_top (.*);
	bsd_checker u_chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("body_sleep_detector_unit verification failed");
			$finish;
		end
	end

	// receiver side: random stall bursts, one long hold-off on request
	initial begin : receiver
		int  seg;
		bit  busy;
		seg = 0;
		busy = 1'b1;
		forever begin
			@(posedge clk);
			seg++;
			if (seg % 64 == 0)
				busy = ($urandom_range(0, 2) != 0);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && busy && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic offer(input body_word_t w);
		words_sent++;
		if (words_sent % 24 == 0)
			sender_busy = ($urandom_range(0, 2) != 0);
		if (!calm && sender_busy && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= w.cmd;
		body_index <= w.a;
		other_index <= w.b;
		speed <= w.spd;
		spin_rate <= w.ang;
		force_applied <= w.frc;
		sleep_count_limit <= w.lim;
		pair_active <= w.pact;
		first_static <= w.fst;
		second_static <= w.sst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop sending and wait for every outstanding result word
	task automatic drain_words();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] bias_v,
		input logic [CFG_DATA_W-1:0] sleep_v, input logic [CFG_DATA_W-1:0] wake_v);
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_BIAS;
		cfg_data <= bias_v;
		@(posedge clk);
		cfg_index <= REG_SLEEP_LIM;
		cfg_data <= sleep_v;
		@(posedge clk);
		cfg_index <= REG_WAKE_LIM;
		cfg_data <= wake_v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic body_word_t upd(input logic [IDX_W-1:0] b, input logic [15:0] s,
		input logic [15:0] g, input logic f, input logic [CNT_W-1:0] lim);
		body_word_t w;
		w.cmd = CMD_UPDATE;
		w.a = b;
		w.b = IDX_W'($urandom);
		w.spd = s;
		w.ang = g;
		w.frc = f;
		w.lim = lim;
		w.pact = 1'($urandom);
		w.fst = 1'($urandom);
		w.sst = 1'($urandom);
		return w;
	endfunction

	function automatic body_word_t hit(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y,
		input logic act, input logic fs, input logic ss);
		body_word_t w;
		w = upd(x, 16'($urandom), 16'($urandom), 1'($urandom), CNT_W'($urandom));
		w.cmd = CMD_COLLIDE;
		w.b = y;
		w.pact = act;
		w.fst = fs;
		w.sst = ss;
		return w;
	endfunction

	// small signed speed, keeps the estimate well under the sleep limit
	function automatic logic [15:0] slow(input int span);
		int t;
		t = $urandom_range(0, 2 * span) - span;
		return t[15:0];
	endfunction

	function automatic body_word_t pick_word();
		int         r;
		body_word_t w;
		r = $urandom_range(0, 99);
		if (r < 45)
			w = upd(pool[$urandom_range(0, 5)], slow(15), slow(15), 1'b0,
				CNT_W'($urandom_range(1, 6)));
		else if (r < 60)
			w = upd(pool[$urandom_range(0, 5)], 16'($urandom), 16'($urandom), 1'b0,
				CNT_W'($urandom));
		else if (r < 68)
			w = upd(pool[$urandom_range(0, 5)], 16'($urandom), 16'($urandom), 1'b1,
				CNT_W'($urandom));
		else if (r < 88)
			w = hit(pool[$urandom_range(0, 5)], pool[$urandom_range(0, 5)],
				$urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
				$urandom_range(0, 9) == 0);
		else
			w = WORD_W'({$urandom, $urandom});
		return w;
	endfunction

	task automatic random_phase(input int n, input int hold_at, input int pause_at);
		for (int i = 0; i < 6; i++)
			pool[i] = IDX_W'($urandom);
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			if (i == pause_at)
				drain_words();
			offer(pick_word());
		end
	endtask

	initial begin : stimulus
		logic [IDX_W-1:0] lone;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// upper bits of the bias write are not part of the register
		program_regs({16'($urandom), MIN_BIAS_RST}, SLEEP_LIM_RST, WAKE_LIM_RST);

		// extremes of speed, limit zero, force on an awake body
		offer(upd(8'd5, 16'h8000, 16'h8000, 1'b0, 8'd3));
		offer(upd(8'd5, 16'h7FFF, 16'h7FFF, 1'b0, 8'd0));
		offer(upd(8'd5, 16'h0000, 16'hFFFF, 1'b0, 8'd255));
		offer(upd(8'd5, 16'h0001, 16'h0000, 1'b1, 8'd1));
		// quiet updates to sleep, then a sleeping body updated again
		offer(upd(8'd9, 16'h0001, 16'hFFFF, 1'b0, 8'd2));
		offer(upd(8'd9, 16'h0000, 16'h0000, 1'b0, 8'd2));
		offer(upd(8'd9, 16'h0000, 16'h0000, 1'b0, 8'd2));
		offer(upd(8'd10, 16'h0000, 16'h0000, 1'b0, 8'd1));
		// collisions that change nothing
		offer(hit(8'd9, 8'd10, 1'b1, 1'b0, 1'b0));
		offer(hit(8'd5, 8'd7, 1'b1, 1'b0, 1'b0));
		offer(hit(8'd9, 8'd9, 1'b1, 1'b0, 1'b0));
		offer(hit(8'd5, 8'd9, 1'b0, 1'b0, 1'b0));
		offer(hit(8'd5, 8'd9, 1'b1, 1'b1, 1'b0));
		offer(hit(8'd5, 8'd9, 1'b1, 1'b0, 1'b1));
		// fast partner wakes the sleeper, slow partner does not
		offer(hit(8'd9, 8'd5, 1'b1, 1'b0, 1'b0));
		offer(upd(8'd11, 16'h0001, 16'h0000, 1'b0, 8'd0));
		offer(hit(8'd11, 8'd10, 1'b1, 1'b0, 1'b0));
		offer(upd(8'd10, 16'h0000, 16'h0000, 1'b1, 8'd0));
		// index extremes
		offer(upd(8'd255, 16'h5555, 16'hAAAA, 1'b0, 8'd255));
		offer(upd(8'd0, 16'h0000, 16'h0000, 1'b0, 8'd1));
		offer(hit(8'd0, 8'd255, 1'b1, 1'b0, 1'b0));
		offer(hit(8'd255, 8'd0, 1'b1, 1'b0, 1'b0));

		// long quiet run on one body: counter climbs to 255 and saturates
		lone = IDX_W'($urandom);
		for (int i = 0; i < 260; i++)
			offer(upd(lone, slow(3), slow(3), 1'b0, 8'd255));
		random_phase(PHASE_WORDS, 40, -1);

		drain_words();
		program_regs(32'd0, 32'hFFFF_FFFF, 32'd0);
		random_phase(PHASE_WORDS, -1, 60);

		drain_words();
		program_regs(32'h0000_FFFF, 32'd0, 32'hFFFF_FFFF);
		random_phase(PHASE_WORDS, 30, -1);

		drain_words();
		program_regs($urandom_range(0, 65535), $urandom_range(0, 20000),
			$urandom_range(0, 60000));
		random_phase(PHASE_WORDS, -1, 50);

		// closing stretch at full rate on both sides
		drain_words();
		calm = 1'b1;
		program_regs(MIN_BIAS_RST, SLEEP_LIM_RST, WAKE_LIM_RST);
		random_phase(PHASE_WORDS, -1, -1);

		drain_words();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("body_sleep_detector_unit verification clean");
		else
			$display("body_sleep_detector_unit verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/bsd_pkg.sv
hdl/bsd_store.sv
hdl/bsd_datapath.sv
hdl/bsd_ctrl.sv
hdl/body_sleep_detector_unit.sv
hdl/bsd_checker.sv
sim/bsd_checker.sv
sim/body_sleep_detector_unit_tb.sv
